[design/tpps_pkg.sv]
package tpps_pkg;

  // Largest timer factor (prescaler or period plus one)
  localparam int unsigned FACTOR_MAX = 65535;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_W);
  localparam int unsigned CLK_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [DIV_W-1:0] FACTOR_MAX_W = DIV_W'(FACTOR_MAX);
  localparam logic [DIV_W-1:0] DIV_LIMIT    = DIV_W'(64'(FACTOR_MAX) * 64'(FACTOR_MAX));

  localparam logic [CLK_W-1:0] BUS_CLOCK_RST  = CLK_W'(36000000);
  localparam logic [CLK_W-1:0] CORE_CLOCK_RST = CLK_W'(72000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS_CLOCK  = 2'd0,
    CFG_CORE_CLOCK = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

[design/tpps_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module tpps_div (
  input  logic               clk,
  input  logic               rst,
  input  tpps_pkg::div_req_t req,
  output tpps_pkg::div_rsp_t rsp
);
  import tpps_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = !diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quo, remainder: rem};

endmodule

[design/timer_prescaler_period_search.sv]
// Timer prescaler / period search.
// Input channel (in_valid/in_ready, sample_rate_hz): one transfer is one request.
// Output channel (out_valid/out_ready): one result per request, carrying
// prescaler, period, exact and status (1 = zero rate, zero divider or divider
// above FACTOR_MAX squared; other fields then 0).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 bus clock,
// index 1 core clock, low 31 bits kept, other indexes ignored; always ready.
// Timer clock is the bus clock when core equals bus, else twice the bus clock.
// All division is done by one shared 32-step divider: a zero rate needs none;
//   a divider up to FACTOR_MAX or an error needs one division; a search needs
//   two, then one per trial factor tried (up to 65534 trial factors).
// One request at a time: in_ready is high only when no search is running.
// The result sits in an output register; a stalled receiver lets the next
// request be accepted, and a finished search then waits until that register
// frees. Reset (rst, synchronous) empties the output, idles the sequencer and
// loads bus 36 MHz, core 72 MHz.
module timer_prescaler_period_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_rate_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] prescaler,
  output logic [15:0] period,
  output logic        exact,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tpps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import tpps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLK_DIV,    // timer clock / rate
    ST_FIRST_DIV,  // divider / FACTOR_MAX, start of search
    ST_TRIAL,      // divider % trial factor
    ST_OUT         // wait for the output register
  } state_t;

  state_t state;

  logic [CLK_W-1:0]    bus_clock_hz;
  logic [CLK_W-1:0]    core_clock_hz;
  logic [DIV_W-1:0]    timer_clk;

  // shared divider operands
  logic                div_start;
  logic [DIV_W-1:0]    dividend;
  logic [DIV_W-1:0]    divisor;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // search state
  logic [FACTOR_W-1:0] trial;
  logic [FACTOR_W-1:0] trial_next;
  logic [FACTOR_W-1:0] best_r;
  logic [FACTOR_W-1:0] best_q;
  logic [DIV_W-1:0]    best_err;

  // pending result
  logic [FACTOR_W-1:0] res_prescaler;
  logic [FACTOR_W-1:0] res_period;
  logic                res_exact;
  logic                res_status;

  // trial evaluation
  logic                improve;
  logic [FACTOR_W-1:0] cand_r;
  logic [FACTOR_W-1:0] cand_q;
  logic [DIV_W-1:0]    cand_err;
  logic                stop;
  logic [FACTOR_W-1:0] lo;
  logic [FACTOR_W-1:0] hi;
  logic [FACTOR_W-1:0] first;

  assign timer_clk = (core_clock_hz == bus_clock_hz) ? {1'b0, bus_clock_hz}
                                                      : {bus_clock_hz, 1'b0};

  assign div_req = '{start: div_start, dividend: dividend, divisor: divisor};

  tpps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // first trial factor, clipped to FACTOR_MAX
  assign first = (div_rsp.quotient >= FACTOR_MAX_W) ? FACTOR_W'(FACTOR_MAX)
                                                    : div_rsp.quotient[FACTOR_W-1:0] + 1'b1;

  // keep the first factor with the least remainder
  assign improve  = div_rsp.remainder < best_err;
  assign cand_r   = improve ? trial : best_r;
  assign cand_q   = improve ? div_rsp.quotient[FACTOR_W-1:0] : best_q;
  assign cand_err = improve ? div_rsp.remainder : best_err;
  assign stop     = (div_rsp.remainder == '0) || (trial == FACTOR_W'(FACTOR_MAX));
  assign lo       = (cand_r > cand_q) ? cand_q : cand_r;
  assign hi       = (cand_r > cand_q) ? cand_r : cand_q;
  assign trial_next = trial + 1'b1;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      div_start     <= 1'b0;
      bus_clock_hz  <= BUS_CLOCK_RST;
      core_clock_hz <= CORE_CLOCK_RST;
    end else begin
      // start is a one-cycle pulse; no divider result is due the cycle after it
      if (div_start) begin
        div_start <= 1'b0;
      end

      // ST_OUT reloads the output register in the same cycle it drains
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_BUS_CLOCK:  bus_clock_hz  <= cfg_data[CLK_W-1:0];
          CFG_CORE_CLOCK: core_clock_hz <= cfg_data[CLK_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (sample_rate_hz == '0) begin
              res_prescaler <= '0;
              res_period    <= '0;
              res_exact     <= 1'b0;
              res_status    <= 1'b1;
              state         <= ST_OUT;
            end else begin
              dividend  <= timer_clk;
              divisor   <= sample_rate_hz;
              div_start <= 1'b1;
              state     <= ST_CLK_DIV;
            end
          end
        end

        ST_CLK_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0 || div_rsp.quotient > DIV_LIMIT) begin
              res_prescaler <= '0;
              res_period    <= '0;
              res_exact     <= 1'b0;
              res_status    <= 1'b1;
              state         <= ST_OUT;
            end else if (div_rsp.quotient <= FACTOR_MAX_W) begin
              // fits one factor: prescaler 0
              res_prescaler <= '0;
              res_period    <= div_rsp.quotient[FACTOR_W-1:0] - 1'b1;
              res_exact     <= 1'b1;
              res_status    <= 1'b0;
              state         <= ST_OUT;
            end else begin
              dividend  <= div_rsp.quotient;
              divisor   <= FACTOR_MAX_W;
              div_start <= 1'b1;
              state     <= ST_FIRST_DIV;
            end
          end
        end

        ST_FIRST_DIV: begin
          if (div_rsp.done) begin
            trial     <= first;
            best_r    <= first;
            best_q    <= '0;
            best_err  <= '1;
            divisor   <= DIV_W'(first);
            div_start <= 1'b1;
            state     <= ST_TRIAL;
          end
        end

        ST_TRIAL: begin
          if (div_rsp.done) begin
            best_r   <= cand_r;
            best_q   <= cand_q;
            best_err <= cand_err;
            if (stop) begin
              res_prescaler <= lo - 1'b1;
              res_period    <= hi - 1'b1;
              res_exact     <= (cand_err == '0);
              res_status    <= 1'b0;
              state         <= ST_OUT;
            end else begin
              trial     <= trial_next;
              divisor   <= DIV_W'(trial_next);
              div_start <= 1'b1;
            end
          end
        end

        ST_OUT: begin
          if (!out_valid || out_ready) begin
            prescaler <= res_prescaler;
            period    <= res_period;
            exact     <= res_exact;
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider never runs while a new request can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_rsp.busy)
    else $error("divider busy while accepting a request");

  // divider results only arrive while the sequencer waits for them
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_CLK_DIV || state == ST_FIRST_DIV || state == ST_TRIAL))
    else $error("divider result outside a wait state");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (prescaler == '0 && period == '0 && !exact))
    else $error("error result with nonzero fields");

  // prescaler is the smaller factor
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> (period >= prescaler))
    else $error("prescaler larger than period");

endmodule

[tb/timer_setup_checker.sv]
module timer_setup_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [31:0]                    sample_rate_hz,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [15:0]                    prescaler,
  input  logic [15:0]                    period,
  input  logic                           exact,
  input  logic                           status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tpps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpps_pkg::*;

  typedef struct packed {
    logic [15:0] psc;
    logic [15:0] arr;
    logic        is_exact;
    logic        err;
  } timer_setup_t;

  localparam logic [63:0] SQUARE_LIMIT = 64'(FACTOR_MAX) * 64'(FACTOR_MAX);

  logic [30:0]  bus_hz;
  logic [30:0]  core_hz;
  timer_setup_t setup_q[$];
  int           mismatches;

  // Split timer_clock / rate into prescaler and period factors.
  function automatic timer_setup_t solve_timer_setup(logic [31:0] rate, logic [30:0] bus,
                                                     logic [30:0] core);
    timer_setup_t res;
    logic [31:0]  tclk;
    logic [31:0]  div;
    logic [31:0]  first;
    logic [31:0]  best;
    logic [31:0]  best_rem;
    logic [31:0]  rem;
    logic [31:0]  other;
    logic [31:0]  lo;
    logic [31:0]  hi;
    res = '{psc: 16'd0, arr: 16'd0, is_exact: 1'b0, err: 1'b1};
    tclk = (core == bus) ? {1'b0, bus} : {bus, 1'b0};
    if (rate == 32'd0) return res;
    div = tclk / rate;
    if (div == 32'd0 || 64'(div) > SQUARE_LIMIT) return res;
    if (div <= FACTOR_MAX) begin
      lo = 32'd1;
      hi = div;
      res.is_exact = 1'b1;
    end else begin
      first = div / FACTOR_MAX + 32'd1;
      if (first > FACTOR_MAX) first = FACTOR_MAX;
      best = first;
      best_rem = 32'hFFFF_FFFF;
      // first exact factor wins, else the first one with least remainder
      for (int unsigned r = first; r <= FACTOR_MAX; r++) begin
        rem = div % r;
        if (rem < best_rem) begin
          best_rem = rem;
          best = r;
        end
        if (rem == 32'd0) break;
      end
      other = div / best;
      res.is_exact = (best_rem == 32'd0);
      if (best > other) begin
        lo = other;
        hi = best;
      end else begin
        lo = best;
        hi = other;
      end
    end
    res.psc = 16'(lo - 32'd1);
    res.arr = 16'(hi - 32'd1);
    res.err = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    timer_setup_t want;
    timer_setup_t got;
    if (rst) begin
      bus_hz = BUS_CLOCK_RST;
      core_hz = CORE_CLOCK_RST;
      setup_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BUS_CLOCK:  bus_hz = cfg_data[30:0];
          CFG_CORE_CLOCK: core_hz = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        setup_q.push_back(solve_timer_setup(sample_rate_hz, bus_hz, core_hz));
      if (out_valid && out_ready) begin
        got = '{psc: prescaler, arr: period, is_exact: exact, err: status};
        if (setup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result psc=%0d arr=%0d exact=%0b status=%0b",
                     $time, got.psc, got.arr, got.is_exact, got.err);
        end else begin
          want = setup_q.pop_front();
          if (got.psc !== want.psc || got.arr !== want.arr ||
              got.is_exact !== want.is_exact || got.err !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp psc=%0d arr=%0d exact=%0b status=%0b,", $time,
                       want.psc, want.arr, want.is_exact, want.err,
                       " got psc=%0d arr=%0d exact=%0b status=%0b",
                       got.psc, got.arr, got.is_exact, got.err);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= setup_q.size();
  end

endmodule

[tb/tb_timer_prescaler_period_search.sv]
module tb_timer_prescaler_period_search;
  timeunit 1ns;
  timeprecision 1ps;
  import tpps_pkg::*;

  // Searches longer than this many trial factors are steered away from.
  localparam int unsigned MAX_TRIALS    = 400;
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;
  localparam int          SETTLE_CYCLES = 200;
  // Indexes past the bus and core clock registers; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          sample_rate_hz = 32'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          prescaler;
  logic [15:0]          period;
  logic                 exact;
  logic                 status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BUS_CLOCK;
  logic [31:0]          cfg_data = 32'd0;

  int                   fail_count;
  int                   pending_count;
  int unsigned          cycles = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  // Shadow of the clock registers, used to steer stimulus away from very long
  // searches and to aim rates at the small-divider path.
  logic [30:0]          bus_now = BUS_CLOCK_RST;
  logic [30:0]          core_now = CORE_CLOCK_RST;
  logic [31:0]          directed_q[$];

  timer_prescaler_period_search DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_rate_hz (sample_rate_hz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prescaler      (prescaler),
    .period         (period),
    .exact          (exact),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  timer_setup_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_rate_hz (sample_rate_hz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prescaler      (prescaler),
    .period         (period),
    .exact          (exact),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a runaway search ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, one fresh decision per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [31:0] timer_clock_now();
    return (core_now == bus_now) ? {1'b0, bus_now} : {bus_now, 1'b0};
  endfunction

  // True when the block settles this rate quickly: error, small divider, or an
  // exact factor (or the end of the factor range) within MAX_TRIALS trials.
  function automatic bit quick_search(logic [31:0] rate);
    logic [31:0] div;
    logic [31:0] first;
    if (rate == 32'd0) return 1'b1;
    div = timer_clock_now() / rate;
    if (div <= FACTOR_MAX) return 1'b1;
    first = div / FACTOR_MAX + 32'd1;
    if (first + MAX_TRIALS > FACTOR_MAX) return 1'b1;
    for (int unsigned r = first; r < first + MAX_TRIALS; r++)
      if (div % r == 32'd0) return 1'b1;
    return 1'b0;
  endfunction

  // Mix of full-width rates (mostly zero divider), low rates (large dividers
  // and searches), log-spread rates, and rates aimed at the small-divider path.
  function automatic logic [31:0] random_rate();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(1, 4000);
      2:       return $urandom() >> $urandom_range(0, 31);
      default: return timer_clock_now() / $urandom_range(1, FACTOR_MAX);
    endcase
  endfunction

  // Register write; valid stays up when another write follows directly.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      CFG_BUS_CLOCK:  bus_now = data[30:0];
      CFG_CORE_CLOCK: core_now = data[30:0];
      default: ;
    endcase
  endtask

  // One request transfer. Valid is only lowered for an idle gap, so a
  // back-to-back request keeps it high with a new payload.
  task automatic send_rate(input logic [31:0] rate);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_rate_hz <= rate;
    do @(posedge clk); while (!in_ready);
  endtask

  // Directed rates from directed_q, then random ones, then wait until every
  // expected result has come back so the block is idle for the next writes.
  task automatic run_rates(input int send_pct, input int recv_pct, input int n_random);
    logic [31:0] rate;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (directed_q.size() != 0) begin
      rate = directed_q.pop_front();
      if (quick_search(rate)) send_rate(rate);
    end
    repeat (n_random) begin
      rate = random_rate();
      for (int k = 0; k < 64 && !quick_search(rate); k++) rate = random_rate();
      if (!quick_search(rate)) rate = 32'hFFFF_FFFF;
      send_rate(rate);
    end
    in_valid <= 1'b0;
    // pending is a registered copy of the checker's queue size, so let it catch up
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] clk_word;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset clocks (timer 72 MHz), first with no idling: zero rate, rate above the
    // timer clock, divider 1, dividers just over and under FACTOR_MAX, searches.
    directed_q = {32'd0, 32'd1, 32'd2, 32'd1098, 32'd1099, 32'd44100, 32'd48000,
                  32'd36_000_000, 32'd72_000_000, 32'd72_000_001, 32'h8000_0000,
                  32'hFFFF_FFFF};
    run_rates(0, 0, 0);
    run_rates(84, 0, 14);

    // Bus = core = max (bit 31 of the write dropped): no doubling, prime clock.
    write_reg(CFG_BUS_CLOCK, 32'hFFFF_FFFF, 1'b0);
    write_reg(CFG_CORE_CLOCK, 32'h7FFF_FFFF, 1'b1);
    directed_q = {32'h7FFF_FFFF, 32'h4000_0000, 32'd3};
    run_rates(0, 84, 14);

    // Max bus, core 1: doubled clock, rate 1 lands above FACTOR_MAX^2.
    write_reg(CFG_BUS_CLOCK, 32'h7FFF_FFFF, 1'b0);
    write_reg(CFG_CORE_CLOCK, 32'd1, 1'b1);
    directed_q = {32'd1, 32'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    run_rates(21, 21, 14);

    // One hertz timer clock: only rate 1 gives a divider.
    write_reg(CFG_BUS_CLOCK, 32'd1, 1'b0);
    write_reg(CFG_CORE_CLOCK, 32'h8000_0001, 1'b1);
    directed_q = {32'd0, 32'd1, 32'd2};
    run_rates(0, 0, 6);

    // Divider just under FACTOR_MAX^2: first trial factor is FACTOR_MAX itself,
    // so the least-remainder fallback shows up cheaply.
    write_reg(CFG_BUS_CLOCK, 32'd2_147_400_000, 1'b0);
    write_reg(CFG_CORE_CLOCK, $urandom(), 1'b1);
    directed_q = {32'd1, 32'd2};
    run_rates(84, 0, 14);

    // Random clock, core equal to bus once the top bit is masked off.
    clk_word = $urandom();
    write_reg(CFG_BUS_CLOCK, clk_word, 1'b0);
    write_reg(CFG_CORE_CLOCK, {~clk_word[31], clk_word[30:0]}, 1'b1);
    run_rates(0, 84, 14);

    // Writes to unused indexes must not land; zero bus clock makes every
    // request an error.
    write_reg(CFG_SPARE_LO, $urandom(), 1'b0);
    write_reg(CFG_SPARE_HI, $urandom(), 1'b0);
    write_reg(CFG_BUS_CLOCK, 32'h8000_0000, 1'b1);
    directed_q = {32'd1, 32'd0};
    run_rates(21, 21, 6);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
